// File: rtl/stt_pkg.sv
package stt_pkg;

    localparam longint unsigned MAX_TEXT_LENGTH_DEF = 64'd65535;
    localparam int unsigned     QUEUE_DEPTH_DEF     = 4;

    localparam int unsigned POS_W = 16;
    localparam int unsigned LEN_W = 16;

    typedef enum logic [2:0] {
        KIND_ID      = 3'd0,
        KIND_INT     = 3'd1,
        KIND_BINOP   = 3'd2,
        KIND_ASSIGN  = 3'd3,
        KIND_NEWLINE = 3'd4,
        KIND_ERROR   = 3'd5
    } t_kind;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_BANG  = 8'h21;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   start;
        logic [LEN_W-1:0]   length;
    } t_token;

    // tokens caused by one character, oldest in tok0
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_pair;

endpackage

// File: rtl/stt_front.sv
module stt_front #(
    parameter longint unsigned MAX_TEXT_LENGTH = stt_pkg::MAX_TEXT_LENGTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_text_char,
    input  logic           i_end_of_text,
    output logic           o_push,
    output stt_pkg::t_pair o_pair
);

    localparam logic [stt_pkg::POS_W-1:0] POS_CAP =
        (MAX_TEXT_LENGTH < 64'd65535) ? stt_pkg::POS_W'(MAX_TEXT_LENGTH) : 16'hFFFF;

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_IDENT = 3'd1,
        M_INT   = 3'd2,
        M_OPER  = 3'd3,
        M_SKIP  = 3'd4
    } t_mode;

    t_mode                      r_mode, n_mode;
    logic [stt_pkg::POS_W-1:0]  r_begin, n_begin;
    logic [stt_pkg::POS_W-1:0]  r_pos;

    logic is_letter, is_digit, is_op, is_nl, is_blank;
    logic sc_emit, sc_set, use_sc;
    stt_pkg::t_kind sc_kind;
    t_mode sc_mode;
    logic a_v, b_v, c_v;
    stt_pkg::t_token a_tok, b_tok, c_tok;

    function automatic logic [stt_pkg::LEN_W-1:0] clamp_len(
        input logic [stt_pkg::POS_W:0]   fin,
        input logic [stt_pkg::POS_W-1:0] beg
    );
        logic [stt_pkg::POS_W:0] d;
        d = fin - {1'b0, beg};
        if (d == '0) begin
            clamp_len = 16'd1;
        end else if (d[stt_pkg::POS_W]) begin
            clamp_len = 16'hFFFF;
        end else begin
            clamp_len = d[stt_pkg::LEN_W-1:0];
        end
    endfunction

    always_comb begin
        is_letter = (i_text_char >= 8'h41 && i_text_char <= 8'h5A) ||
                    (i_text_char >= 8'h61 && i_text_char <= 8'h7A);
        is_digit  = (i_text_char >= 8'h30 && i_text_char <= 8'h39);
        is_op     = (i_text_char == stt_pkg::CH_PLUS)  || (i_text_char == stt_pkg::CH_MINUS) ||
                    (i_text_char == stt_pkg::CH_STAR)  || (i_text_char == stt_pkg::CH_SLASH) ||
                    (i_text_char == stt_pkg::CH_PCT)   || (i_text_char == stt_pkg::CH_GT)    ||
                    (i_text_char == stt_pkg::CH_LT)    || (i_text_char == stt_pkg::CH_EQ)    ||
                    (i_text_char == stt_pkg::CH_BANG);
        is_nl     = (i_text_char == stt_pkg::CH_NL);
        is_blank  = (i_text_char == stt_pkg::CH_SPACE) || (i_text_char == stt_pkg::CH_TAB);

        // what a character does with no token pending
        sc_emit = 1'b0;
        sc_set  = 1'b0;
        sc_kind = stt_pkg::KIND_NEWLINE;
        sc_mode = M_IDLE;
        if (is_nl) begin
            sc_emit = 1'b1;
        end else if (is_blank) begin
            sc_emit = 1'b0;
        end else if (is_op) begin
            sc_mode = M_OPER;
            sc_set  = 1'b1;
        end else if (is_letter) begin
            sc_mode = M_IDENT;
            sc_set  = 1'b1;
        end else if (is_digit) begin
            sc_mode = M_INT;
            sc_set  = 1'b1;
        end else begin
            sc_emit = 1'b1;
            sc_kind = stt_pkg::KIND_ERROR;
            sc_mode = M_SKIP;
        end

        a_v          = 1'b0;
        a_tok.kind   = stt_pkg::KIND_ID;
        a_tok.start  = r_begin;
        a_tok.length = clamp_len({1'b0, r_pos}, r_begin);
        use_sc       = 1'b0;
        n_mode       = r_mode;
        n_begin      = r_begin;

        case (r_mode)
            M_SKIP: begin
                use_sc = 1'b0;
            end
            M_IDENT: begin
                if (!(is_letter || is_digit)) begin
                    a_v    = 1'b1;
                    use_sc = 1'b1;
                end
            end
            M_INT: begin
                if (!is_digit) begin
                    a_v        = 1'b1;
                    a_tok.kind = stt_pkg::KIND_INT;
                    use_sc     = 1'b1;
                end
            end
            M_OPER: begin
                a_v = 1'b1;
                if (i_text_char == stt_pkg::CH_EQ) begin
                    a_tok.kind   = stt_pkg::KIND_ASSIGN;
                    a_tok.length = 16'd2;
                    n_mode       = M_IDLE;
                end else if (i_text_char == stt_pkg::CH_STAR ||
                             i_text_char == stt_pkg::CH_SLASH) begin
                    // operator followed by * or / is rejected
                    a_tok.kind   = stt_pkg::KIND_ERROR;
                    a_tok.length = 16'd2;
                    n_mode       = M_SKIP;
                end else begin
                    a_tok.kind   = stt_pkg::KIND_BINOP;
                    a_tok.length = 16'd1;
                    use_sc       = 1'b1;
                end
            end
            default: begin
                use_sc = 1'b1;
            end
        endcase

        if (use_sc) begin
            n_mode = sc_mode;
            if (sc_set) begin
                n_begin = r_pos;
            end
        end

        b_v          = use_sc && sc_emit;
        b_tok.kind   = sc_kind;
        b_tok.start  = r_pos;
        b_tok.length = 16'd1;

        // end of text flushes a pending token
        c_v          = i_end_of_text &&
                       (n_mode == M_IDENT || n_mode == M_INT || n_mode == M_OPER);
        c_tok.start  = n_begin;
        c_tok.kind   = stt_pkg::KIND_ID;
        c_tok.length = clamp_len({1'b0, r_pos} + 17'd1, n_begin);
        if (n_mode == M_INT) begin
            c_tok.kind = stt_pkg::KIND_INT;
        end else if (n_mode == M_OPER) begin
            c_tok.kind   = stt_pkg::KIND_BINOP;
            c_tok.length = 16'd1;
        end

        o_push     = i_accept && (a_v || b_v || c_v);
        o_pair.two = (a_v && b_v) || (a_v && c_v) || (b_v && c_v);
        if (a_v) begin
            o_pair.tok0 = a_tok;
            o_pair.tok1 = b_v ? b_tok : c_tok;
        end else if (b_v) begin
            o_pair.tok0 = b_tok;
            o_pair.tok1 = c_tok;
        end else begin
            o_pair.tok0 = c_tok;
            o_pair.tok1 = c_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_begin <= '0;
            r_pos   <= '0;
        end else if (i_accept) begin
            if (i_end_of_text) begin
                r_mode  <= M_IDLE;
                r_begin <= '0;
                r_pos   <= '0;
            end else begin
                r_mode  <= n_mode;
                r_begin <= n_begin;
                if (r_pos < POS_CAP) begin
                    r_pos <= r_pos + 16'd1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_eot_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_end_of_text |=> r_mode == M_IDLE && r_pos == '0)
        else $error("end of text did not return the scanner to idle");
    a_skip_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_end_of_text && r_mode == M_SKIP |=> r_mode == M_SKIP && !$past(o_push))
        else $error("skip mode left or produced a token before end of text");
    a_pos_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CAP && r_begin <= r_pos)
        else $error("position past its cap or token begin ahead of position");
`endif

endmodule

// File: rtl/stt_queue.sv
module stt_queue #(
    parameter int unsigned DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stt_pkg::t_pair i_pair,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output stt_pkg::t_pair o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    stt_pkg::t_pair     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request written into a full queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");
`endif

endmodule

// File: rtl/stt_back.sv
module stt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_nonempty,
    input  stt_pkg::t_pair i_head,
    output logic           o_pop_queue,
    output logic           empty,
    input  logic           pop,
    output logic [2:0]     o_token_kind,
    output logic [15:0]    o_token_start,
    output logic [15:0]    o_token_length,
    output logic           o_last_of_run
);

    logic           r_valid;
    logic           r_idx;
    stt_pkg::t_pair r_pair;
    logic           take, load;
    stt_pkg::t_token cur;

    assign take        = pop && r_valid;
    // the pair is done when its last token leaves
    assign load        = !r_valid || (take && (r_idx || !r_pair.two));
    assign o_pop_queue = load && i_nonempty;

    assign cur            = r_idx ? r_pair.tok1 : r_pair.tok0;
    assign empty          = !r_valid;
    assign o_token_kind   = cur.kind;
    assign o_token_start  = cur.start;
    assign o_token_length = cur.length;
    assign o_last_of_run  = r_idx || !r_pair.two;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pair <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (load) begin
            r_valid <= i_nonempty;
            r_idx   <= 1'b0;
        end else if (take) begin
            r_idx <= 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_second_only_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx |-> r_valid && r_pair.two)
        else $error("second token shown for a single-token pair");
    a_idx_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_idx) |-> $past(take) && !$past(r_idx))
        else $error("second token selected without taking the first");
`endif

endmodule

// File: rtl/source_text_tokenizer.sv
// a token is written into the queue at the edge that accepts the character completing it
// and is then registered into the output stage, where it is on the result ports and can be popped
// throughput: one character per cycle on the input while full is low, one token per cycle
// on the output; a character that completes two tokens holds the output for both in turn, and a
// 4-entry queue between scanner and output stage absorbs those bursts
// reset: synchronous, active low; clears scanner state, position, queue and output stage
module source_text_tokenizer #(
    parameter longint unsigned MAX_TEXT_LENGTH = stt_pkg::MAX_TEXT_LENGTH_DEF,
    parameter int unsigned     QUEUE_DEPTH     = stt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_char,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);

    logic           accept;
    logic           q_push, q_pop, q_nonempty;
    stt_pkg::t_pair q_in, q_head;

    assign accept = push && !full;

    stt_front #(
        .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .o_push        (q_push),
        .o_pair        (q_in)
    );

    stt_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_pair     (q_in),
        .o_full     (full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    stt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nonempty     (q_nonempty),
        .i_head         (q_head),
        .o_pop_queue    (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
